[src/assert_macros.svh]
// Assertion helpers for the checker file (dfp_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, muted while rst_n is low.
`define DFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dfp_pkg.sv]
package dfp_pkg;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_HEADER  = 3'd1,
    MODE_START   = 3'd2,
    MODE_TEXT    = 3'd3,
    MODE_INT     = 3'd4,
    MODE_FRAC    = 3'd5,
    MODE_QUOTED  = 3'd6,
    MODE_QCLOSED = 3'd7
  } dfp_mode_t;

  // Field kinds as reported on the result channel.
  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_TEXT = 2'd2
  } dfp_kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEPARATOR = 2'd0;
  localparam logic [1:0] CFG_DECIMAL   = 2'd1;
  localparam logic [1:0] CFG_SKIP_HDR  = 2'd2;
  localparam logic [1:0] CFG_COLUMNS   = 2'd3;

  localparam logic [7:0] SEPARATOR_RST = 8'd44;
  localparam logic [7:0] DECIMAL_RST   = 8'd46;
  localparam logic [6:0] COLUMNS_RST   = 7'd1;

  localparam logic [7:0] QUOTE_BYTE   = 8'd34;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] DIGIT_LO     = 8'd48;
  localparam logic [7:0] DIGIT_HI     = 8'd57;

  localparam int KIND_BITS = 3;

  // Per-field attributes that travel with a closed field.
  typedef struct packed {
    dfp_kind_t kind;
    logic      last;
  } dfp_close_t;

  function automatic logic [KIND_BITS-1:0] kind_mask(dfp_kind_t k);
    logic [KIND_BITS-1:0] m;
    case (k)
      KIND_INT:  m = 3'b001;
      KIND_DEC:  m = 3'b010;
      KIND_TEXT: m = 3'b100;
      default:   m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

[src/dfp_col_table.sv]
module dfp_col_table #(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16,
  parameter int COL_W       = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ev_valid,
  output logic                   ev_ready,
  input  logic [COL_W-1:0]       ev_col,
  input  logic [LENGTH_BITS-1:0] ev_len,
  input  dfp_pkg::dfp_close_t    ev_info,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_column_index,
  output logic [1:0]             out_field_kind,
  output logic [LENGTH_BITS-1:0] out_field_length,
  output logic [2:0]             out_kinds_seen,
  output logic [LENGTH_BITS-1:0] out_longest_length,
  output logic                   out_final_field
);

  localparam int WORD_W = dfp_pkg::KIND_BITS + LENGTH_BITS;

  logic [WORD_W-1:0] mem [MAX_COLUMNS];
  logic [WORD_W-1:0] rd_data_r;

  logic                   clearing_r, clearing_nxt;
  logic [COL_W-1:0]       clr_idx_r, clr_idx_nxt;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]       s1_col_r;
  logic [LENGTH_BITS-1:0] s1_len_r;
  dfp_pkg::dfp_close_t    s1_info_r;

  logic                   wb_valid_r;
  logic [COL_W-1:0]       wb_col_r;
  logic [WORD_W-1:0]      wb_word_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             out_col_r;
  logic [1:0]             out_kind_r;
  logic [LENGTH_BITS-1:0] out_len_r;
  logic [2:0]             out_kinds_r;
  logic [LENGTH_BITS-1:0] out_long_r;
  logic                   out_last_r;

  logic                   s1_adv;
  logic                   s1_fire;
  logic [WORD_W-1:0]      base_word;
  logic [2:0]             new_kinds;
  logic [LENGTH_BITS-1:0] base_long;
  logic [LENGTH_BITS-1:0] new_long;
  logic [WORD_W-1:0]      new_word;
  logic                   wr_en;
  logic [COL_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic [COL_W+5:0]       col_ext;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign ev_ready = !clearing_r && (!s1_valid_r || s1_adv);

  // The write of the previous field is not yet visible to a read issued in the same edge.
  assign base_word = (wb_valid_r && (wb_col_r == s1_col_r)) ? wb_word_r : rd_data_r;
  assign base_long = base_word[LENGTH_BITS-1:0];
  assign new_kinds = base_word[WORD_W-1:LENGTH_BITS] | dfp_pkg::kind_mask(s1_info_r.kind);
  assign new_long  = (base_long < s1_len_r) ? s1_len_r : base_long;
  assign new_word  = {new_kinds, new_long};
  assign col_ext   = {6'b0, s1_col_r};

  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + COL_W'(1);
      if (clr_idx_r == COL_W'(MAX_COLUMNS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    wr_en   = clearing_r || s1_fire;
    wr_addr = clearing_r ? clr_idx_r : s1_col_r;
    wr_data = clearing_r ? '0 : new_word;

    s1_valid_nxt = s1_valid_r;
    if (ev_valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ev_valid) begin
      rd_data_r <= mem[ev_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_idx_r   <= clr_idx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        wb_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      s1_col_r  <= ev_col;
      s1_len_r  <= ev_len;
      s1_info_r <= ev_info;
    end
    if (s1_fire) begin
      wb_col_r    <= s1_col_r;
      wb_word_r   <= new_word;
      out_col_r   <= col_ext[5:0];
      out_kind_r  <= s1_info_r.kind;
      out_len_r   <= s1_len_r;
      out_kinds_r <= new_kinds;
      out_long_r  <= new_long;
      out_last_r  <= s1_info_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_column_index   = out_col_r;
  assign out_field_kind     = out_kind_r;
  assign out_field_length   = out_len_r;
  assign out_kinds_seen     = out_kinds_r;
  assign out_longest_length = out_long_r;
  assign out_final_field    = out_last_r;

endmodule

[src/delimited_field_type_profiler_core.sv]
// Channel  | Handshake              | Beat contents
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | in_data_byte, in_end_of_data
// result   | out_valid / out_ready  | column, kind, length, kinds seen, longest, final
// config   | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
// One input beat is taken per cycle while in_ready is high; a field that closes yields its
// result beat after the column table read stage and then the merge into the output register.
// The column table is one memory with a single write port; each closed field does one
// read-modify-write of its column entry, so the table sets the one-beat-per-cycle rate.
// After reset a clearing pass zeroes every table entry, with in_ready low throughout.
// A stalled result beat holds one more closed field in the merge stage; only then does
// in_ready drop.
module delimited_field_type_profiler_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_column_index,
  output logic [1:0]             out_field_kind,
  output logic [LENGTH_BITS-1:0] out_field_length,
  output logic [2:0]             out_kinds_seen,
  output logic [LENGTH_BITS-1:0] out_longest_length,
  output logic                   out_final_field,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_wdata
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  // Wide enough for the column count register and for one past the last column.
  localparam int CNT_W = (COL_W + 1 > 7) ? COL_W + 1 : 7;

  // Configuration registers.
  logic [7:0] sep_r;
  logic [7:0] dp_r;
  logic       skip_r;
  logic [6:0] ccount_r;

  // Scanner state.
  dfp_pkg::dfp_mode_t     mode_r, mode_nxt, mode_eff;
  logic                   text_r, text_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   open_r, open_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;

  logic                   in_fire;
  logic                   close;
  logic                   term;
  logic                   term_nl;
  logic                   grow;
  dfp_pkg::dfp_close_t    cl_info;
  logic                   is_quote, is_nl, is_sep, is_dp, is_digit;
  logic [CNT_W-1:0]       col_p1;
  logic [CNT_W-1:0]       cnt_eff;
  logic [COL_W-1:0]       col_adv;

  assign in_fire  = in_valid && in_ready;
  assign is_quote = (in_data_byte == dfp_pkg::QUOTE_BYTE);
  assign is_nl    = (in_data_byte == dfp_pkg::NEWLINE_BYTE);
  assign is_sep   = (in_data_byte == sep_r);
  assign is_dp    = (in_data_byte == dp_r);
  assign is_digit = (in_data_byte >= dfp_pkg::DIGIT_LO) && (in_data_byte <= dfp_pkg::DIGIT_HI);

  // Column advance: wrap at the configured count, clipped to the table depth.
  // A count of zero sends every field to column 0.
  assign col_p1  = CNT_W'(col_r) + CNT_W'(1);
  assign cnt_eff = (CNT_W'(ccount_r) > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS)
                                                           : CNT_W'(ccount_r);
  assign col_adv = (col_p1 >= cnt_eff) ? '0 : col_p1[COL_W-1:0];

  always_comb begin
    mode_eff = mode_r;
    if (mode_r == dfp_pkg::MODE_IDLE) begin
      mode_eff = skip_r ? dfp_pkg::MODE_HEADER : dfp_pkg::MODE_START;
    end
    mode_nxt     = mode_r;
    text_nxt     = text_r;
    len_nxt      = len_r;
    open_nxt     = open_r;
    col_nxt      = col_r;
    close        = 1'b0;
    term         = 1'b0;
    term_nl      = 1'b0;
    grow         = 1'b0;
    cl_info.kind = dfp_pkg::KIND_TEXT;
    cl_info.last = 1'b0;

    if (in_end_of_data) begin
      // End of data closes whatever field is open and rewinds to stream start.
      if (mode_r == dfp_pkg::MODE_INT) begin
        cl_info.kind = text_r ? dfp_pkg::KIND_TEXT : dfp_pkg::KIND_INT;
      end else if (mode_r == dfp_pkg::MODE_FRAC) begin
        cl_info.kind = text_r ? dfp_pkg::KIND_TEXT : dfp_pkg::KIND_DEC;
      end
      cl_info.last = 1'b1;
      close = (mode_r == dfp_pkg::MODE_TEXT) || (mode_r == dfp_pkg::MODE_INT) ||
              (mode_r == dfp_pkg::MODE_FRAC) || (mode_r == dfp_pkg::MODE_QUOTED) ||
              (mode_r == dfp_pkg::MODE_QCLOSED) ||
              ((mode_r == dfp_pkg::MODE_START) && open_r);
      mode_nxt = dfp_pkg::MODE_IDLE;
      open_nxt = 1'b0;
      col_nxt  = '0;
      len_nxt  = '0;
      text_nxt = 1'b0;
    end else begin
      mode_nxt = mode_eff;
      grow     = 1'b1;
      case (mode_eff)
        dfp_pkg::MODE_HEADER: begin
          grow = 1'b0;
          if (is_nl) begin
            mode_nxt = dfp_pkg::MODE_START;
          end
        end
        dfp_pkg::MODE_START, dfp_pkg::MODE_TEXT: begin
          if (is_quote) begin
            mode_nxt = dfp_pkg::MODE_QUOTED;
          end else if (is_nl) begin
            term    = 1'b1;
            term_nl = 1'b1;
          end else if (is_sep) begin
            term = 1'b1;
          end else if ((mode_eff == dfp_pkg::MODE_START) && is_digit) begin
            mode_nxt = dfp_pkg::MODE_INT;
            text_nxt = 1'b0;
          end else begin
            mode_nxt = dfp_pkg::MODE_TEXT;
          end
        end
        dfp_pkg::MODE_INT: begin
          cl_info.kind = text_r ? dfp_pkg::KIND_TEXT : dfp_pkg::KIND_INT;
          if (is_nl) begin
            term    = 1'b1;
            term_nl = 1'b1;
          end else if (is_sep) begin
            term = 1'b1;
          end else if (is_dp) begin
            mode_nxt = dfp_pkg::MODE_FRAC;
            text_nxt = 1'b0;
          end else if (!is_digit) begin
            text_nxt = 1'b1;
          end
        end
        dfp_pkg::MODE_FRAC: begin
          cl_info.kind = text_r ? dfp_pkg::KIND_TEXT : dfp_pkg::KIND_DEC;
          if (is_nl) begin
            term    = 1'b1;
            term_nl = 1'b1;
          end else if (is_sep) begin
            term = 1'b1;
          end else if (!is_digit) begin
            text_nxt = 1'b1;
          end
        end
        dfp_pkg::MODE_QUOTED: begin
          if (is_quote) begin
            mode_nxt = dfp_pkg::MODE_QCLOSED;
          end
        end
        dfp_pkg::MODE_QCLOSED: begin
          if (is_sep) begin
            term = 1'b1;
          end else if (is_nl) begin
            term    = 1'b1;
            term_nl = 1'b1;
          end else if (is_quote) begin
            mode_nxt = dfp_pkg::MODE_QUOTED;
          end
        end
        default: begin
          grow = 1'b0;
        end
      endcase

      if (term) begin
        // A separator leaves an empty field open behind it; a newline does not.
        close    = 1'b1;
        mode_nxt = dfp_pkg::MODE_START;
        open_nxt = !term_nl;
        len_nxt  = '0;
        text_nxt = 1'b0;
        col_nxt  = col_adv;
      end else if (grow) begin
        open_nxt = 1'b1;
        len_nxt  = (len_r == {LENGTH_BITS{1'b1}}) ? len_r : len_r + LENGTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= dfp_pkg::SEPARATOR_RST;
      dp_r     <= dfp_pkg::DECIMAL_RST;
      skip_r   <= 1'b1;
      ccount_r <= dfp_pkg::COLUMNS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dfp_pkg::CFG_SEPARATOR: sep_r    <= cfg_wdata;
        dfp_pkg::CFG_DECIMAL:   dp_r     <= cfg_wdata;
        dfp_pkg::CFG_SKIP_HDR:  skip_r   <= cfg_wdata[0];
        dfp_pkg::CFG_COLUMNS:   ccount_r <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dfp_pkg::MODE_IDLE;
      text_r <= 1'b0;
      len_r  <= '0;
      open_r <= 1'b0;
      col_r  <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      text_r <= text_nxt;
      len_r  <= len_nxt;
      open_r <= open_nxt;
      col_r  <= col_nxt;
    end
  end

  // The closing byte itself is not counted, so the event carries the length so far.
  dfp_col_table #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .LENGTH_BITS (LENGTH_BITS),
    .COL_W       (COL_W)
  ) u_table (
    .clk                (clk),
    .rst_n              (rst_n),
    .ev_valid           (in_fire && close),
    .ev_ready           (in_ready),
    .ev_col             (col_r),
    .ev_len             (len_r),
    .ev_info            (cl_info),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_column_index   (out_column_index),
    .out_field_kind     (out_field_kind),
    .out_field_length   (out_field_length),
    .out_kinds_seen     (out_kinds_seen),
    .out_longest_length (out_longest_length),
    .out_final_field    (out_final_field)
  );

endmodule

[src/dfp_checker.sv]
`include "assert_macros.svh"

module dfp_checker #(
  parameter int LENGTH_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [5:0]             out_column_index,
  input logic [1:0]             out_field_kind,
  input logic [LENGTH_BITS-1:0] out_field_length,
  input logic [2:0]             out_kinds_seen,
  input logic [LENGTH_BITS-1:0] out_longest_length,
  input logic                   out_final_field
);

  logic                       kind_listed;
  logic                       long_ok;
  logic                       out_stall;
  logic [2*LENGTH_BITS+11:0]  result_bus;

  assign kind_listed = ((out_field_kind == dfp_pkg::KIND_INT)  && out_kinds_seen[0]) ||
                       ((out_field_kind == dfp_pkg::KIND_DEC)  && out_kinds_seen[1]) ||
                       ((out_field_kind == dfp_pkg::KIND_TEXT) && out_kinds_seen[2]);
  assign long_ok     = (out_longest_length >= out_field_length);
  assign out_stall   = out_valid && !out_ready;
  assign result_bus  = {out_column_index, out_field_kind, out_field_length,
                        out_kinds_seen, out_longest_length, out_final_field};

  // The table is being cleared in the first cycle after reset.
  `DFP_ASSERT(a_clear_after_reset, $past(!rst_n) |-> !in_ready, "input taken during table clear")

  // The reported kind is always part of the column's kind set.
  `DFP_ASSERT(a_kind_in_set, out_valid |-> kind_listed, "kind missing from column set")

  // The column maximum covers the field just merged into it.
  `DFP_ASSERT(a_longest_covers, out_valid |-> long_ok, "longest length below field length")

  `DFP_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(result_bus)), "stalled beat changed")

endmodule

bind delimited_field_type_profiler_core dfp_checker #(.LENGTH_BITS(LENGTH_BITS)) u_chk (.*);

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS   = 64;
  localparam int LEN_BITS   = 16;
  localparam int LEN_MAX    = (1 << LEN_BITS) - 1;
  localparam int HOLD_LONG  = 400;
  localparam int DRAIN_MAX  = 5000;
  localparam int TIMEOUT_NS = 10_000_000;

  // One completed field as it appears on the result channel.
  typedef struct packed {
    logic [5:0]          column;
    dfp_pkg::dfp_kind_t  kind;
    logic [LEN_BITS-1:0] length;
    logic [2:0]          kinds;
    logic [LEN_BITS-1:0] longest;
    logic                last;
  } field_rec_t;

  // Tracks the scanner and the per-column tables, and holds the fields that
  // the block still owes us, oldest first.
  class column_profile_tracker;
    logic [7:0]         sep_byte;
    logic [7:0]         point_byte;
    logic               skip_hdr;
    logic [6:0]         col_limit;
    dfp_pkg::dfp_mode_t mode;
    bit                 non_digit;
    int unsigned        run_len;
    bit                 field_open;
    int unsigned        col;
    logic [2:0]         kinds_tab[MAX_COLS];
    int unsigned        longest_tab[MAX_COLS];
    field_rec_t         pending_fields[$];
    int                 failures;

    function new();
      sep_byte   = dfp_pkg::SEPARATOR_RST;
      point_byte = dfp_pkg::DECIMAL_RST;
      skip_hdr   = 1'b1;
      col_limit  = dfp_pkg::COLUMNS_RST;
      mode       = dfp_pkg::MODE_IDLE;
      non_digit  = 0;
      run_len    = 0;
      field_open = 0;
      col        = 0;
      foreach (kinds_tab[i]) begin
        kinds_tab[i]   = 3'b000;
        longest_tab[i] = 0;
      end
      failures = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        dfp_pkg::CFG_SEPARATOR: sep_byte = val;
        dfp_pkg::CFG_DECIMAL:   point_byte = val;
        dfp_pkg::CFG_SKIP_HDR:  skip_hdr = val[0];
        dfp_pkg::CFG_COLUMNS:   col_limit = val[6:0];
        default: ;
      endcase
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= dfp_pkg::DIGIT_LO && b <= dfp_pkg::DIGIT_HI;
    endfunction

    // A number turns into text once a stray non-digit has been seen.
    function dfp_pkg::dfp_kind_t number_kind(dfp_pkg::dfp_kind_t clean);
      if (non_digit)
        return dfp_pkg::KIND_TEXT;
      return clean;
    endfunction

    function void close_field(dfp_pkg::dfp_kind_t k, bit last);
      field_rec_t  r;
      int unsigned c;
      int unsigned wrap;
      c = (col >= MAX_COLS) ? 0 : col;
      kinds_tab[c] = kinds_tab[c] | (3'b001 << int'(k));
      if (longest_tab[c] < run_len)
        longest_tab[c] = run_len;
      r.column  = 6'(c);
      r.kind    = k;
      r.length  = LEN_BITS'(run_len);
      r.kinds   = kinds_tab[c];
      r.longest = LEN_BITS'(longest_tab[c]);
      r.last    = last;
      pending_fields.insert(pending_fields.size(), r);
      wrap = (col_limit > MAX_COLS) ? MAX_COLS : col_limit;
      col = (c + 1 >= wrap) ? 0 : c + 1;
      run_len = 0;
      non_digit = 0;
    endfunction

    // A newline leaves no field open; a separator opens the next one.
    function void end_on_byte(dfp_pkg::dfp_kind_t k, bit newline);
      close_field(k, 1'b0);
      mode = dfp_pkg::MODE_START;
      field_open = !newline;
    endfunction

    function void take_beat(logic [7:0] b, logic eod);
      dfp_pkg::dfp_kind_t k;
      if (eod) begin
        if (mode == dfp_pkg::MODE_INT)
          k = number_kind(dfp_pkg::KIND_INT);
        else if (mode == dfp_pkg::MODE_FRAC)
          k = number_kind(dfp_pkg::KIND_DEC);
        else
          k = dfp_pkg::KIND_TEXT;
        if (mode >= dfp_pkg::MODE_TEXT || (mode == dfp_pkg::MODE_START && field_open))
          close_field(k, 1'b1);
        mode = dfp_pkg::MODE_IDLE;
        field_open = 0;
        col = 0;
        run_len = 0;
        non_digit = 0;
        return;
      end
      if (mode == dfp_pkg::MODE_IDLE) begin
        if (skip_hdr)
          mode = dfp_pkg::MODE_HEADER;
        else
          mode = dfp_pkg::MODE_START;
      end
      case (mode)
        dfp_pkg::MODE_HEADER: begin
          if (b == dfp_pkg::NEWLINE_BYTE)
            mode = dfp_pkg::MODE_START;
          return;
        end
        dfp_pkg::MODE_START, dfp_pkg::MODE_TEXT: begin
          if (b == dfp_pkg::QUOTE_BYTE) begin
            mode = dfp_pkg::MODE_QUOTED;
          end else if (b == dfp_pkg::NEWLINE_BYTE) begin
            end_on_byte(dfp_pkg::KIND_TEXT, 1'b1);
            return;
          end else if (b == sep_byte) begin
            end_on_byte(dfp_pkg::KIND_TEXT, 1'b0);
            return;
          end else if (mode == dfp_pkg::MODE_START && is_digit(b)) begin
            mode = dfp_pkg::MODE_INT;
            non_digit = 0;
          end else begin
            mode = dfp_pkg::MODE_TEXT;
          end
        end
        dfp_pkg::MODE_INT: begin
          if (b == dfp_pkg::NEWLINE_BYTE || b == sep_byte) begin
            end_on_byte(number_kind(dfp_pkg::KIND_INT), b == dfp_pkg::NEWLINE_BYTE);
            return;
          end
          if (b == point_byte) begin
            mode = dfp_pkg::MODE_FRAC;
            non_digit = 0;
          end else if (!is_digit(b)) begin
            non_digit = 1;
          end
        end
        dfp_pkg::MODE_FRAC: begin
          if (b == dfp_pkg::NEWLINE_BYTE || b == sep_byte) begin
            end_on_byte(number_kind(dfp_pkg::KIND_DEC), b == dfp_pkg::NEWLINE_BYTE);
            return;
          end
          if (!is_digit(b))
            non_digit = 1;
        end
        dfp_pkg::MODE_QUOTED: begin
          if (b == dfp_pkg::QUOTE_BYTE)
            mode = dfp_pkg::MODE_QCLOSED;
        end
        default: begin
          // Closed quote: the separator wins over a newline here.
          if (b == sep_byte) begin
            end_on_byte(dfp_pkg::KIND_TEXT, 1'b0);
            return;
          end
          if (b == dfp_pkg::NEWLINE_BYTE) begin
            end_on_byte(dfp_pkg::KIND_TEXT, 1'b1);
            return;
          end
          if (b == dfp_pkg::QUOTE_BYTE)
            mode = dfp_pkg::MODE_QUOTED;
        end
      endcase
      if (run_len < LEN_MAX)
        run_len++;
      field_open = 1;
    endfunction

    function void match_field(field_rec_t got);
      field_rec_t want;
      if (pending_fields.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result beat with nothing pending: col %0d kind %0d len %0d",
                   got.column, got.kind, got.length);
        return;
      end
      want = pending_fields.pop_front();
      if (got.column !== want.column || got.kind !== want.kind ||
          got.length !== want.length || got.kinds !== want.kinds ||
          got.longest !== want.longest || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("field mismatch: expected col %0d kind %0d len %0d set %b max %0d fin %b, %s",
                   want.column, want.kind, want.length, want.kinds, want.longest, want.last,
                   $sformatf("got col %0d kind %0d len %0d set %b max %0d fin %b",
                             got.column, got.kind, got.length, got.kinds, got.longest,
                             got.last));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_end_of_data;
  logic                out_valid;
  logic                out_ready;
  logic [5:0]          out_column_index;
  logic [1:0]          out_field_kind;
  logic [LEN_BITS-1:0] out_field_length;
  logic [2:0]          out_kinds_seen;
  logic [LEN_BITS-1:0] out_longest_length;
  logic                out_final_field;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [7:0]          cfg_wdata;

  column_profile_tracker profile;

  // When calm is set neither side idles. A bump of hold_asked makes the
  // result side hold off for a long stretch, counted in its own process.
  bit calm       = 1'b0;
  int hold_asked = 0;
  int beats_sent = 0;

  delimited_field_type_profiler_core #(
    .MAX_COLUMNS(MAX_COLS),
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_data    (in_end_of_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_column_index  (out_column_index),
    .out_field_kind    (out_field_kind),
    .out_field_length  (out_field_length),
    .out_kinds_seen    (out_kinds_seen),
    .out_longest_length(out_longest_length),
    .out_final_field   (out_final_field),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block wedges; far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: errors");
    $finish;
  end

  // Offers one input beat, after a random gap unless calm, and waits for the
  // handshake. Valid is only lowered when a gap is taken, so a back-to-back
  // beat never sees valid dropped and raised within one time step.
  task automatic send_beat(input logic [7:0] b, input logic eod);
    int gap;
    gap = 0;
    if (!calm)
      while (gap < 20 && $urandom_range(99) < 30)
        gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (in_ready !== 1'b1);
    profile.take_beat(b, eod);
    beats_sent++;
  endtask

  task automatic put(input logic [7:0] b);
    send_beat(b, 1'b0);
  endtask

  // The byte lane carries junk on an end-of-data beat; the block must ignore it.
  task automatic end_stream();
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put(8'(dfp_pkg::DIGIT_LO + $urandom_range(9)));
  endtask

  task automatic put_letters(input int n);
    repeat (n) put(8'($urandom_range(97, 122)));
  endtask

  // Writes one configuration register while the block is idle: one register
  // per clock; write_settings drops the enable after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    profile.set_reg(idx, val);
  endtask

  task automatic write_settings(input logic [7:0] sep, input logic [7:0] dec,
                                input logic skip, input logic [7:0] cols);
    write_reg(dfp_pkg::CFG_SEPARATOR, sep);
    write_reg(dfp_pkg::CFG_DECIMAL, dec);
    write_reg(dfp_pkg::CFG_SKIP_HDR, {7'd0, skip});
    write_reg(dfp_pkg::CFG_COLUMNS, cols);
    cfg_wr_en <= 1'b0;
  endtask

  // Stops offering beats until every pending field has come back, then lets
  // the pipeline settle, since a byte that closes nothing may still be inside.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (profile.pending_fields.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // One field body with random shape; the terminator is added by the caller.
  task automatic put_field();
    logic [7:0] inner;
    case ($urandom_range(11))
      0, 1, 2: put_digits($urandom_range(1, 6));
      3, 4: begin
        put_digits($urandom_range(1, 4));
        put(profile.point_byte);
        put_digits($urandom_range(0, 4));
      end
      5: put_letters($urandom_range(1, 8));
      6: begin
        // Quoted text: separators and newlines inside are masked.
        put(dfp_pkg::QUOTE_BYTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(3))
            0:       inner = profile.sep_byte;
            1:       inner = dfp_pkg::NEWLINE_BYTE;
            default: inner = 8'($urandom_range(255));
          endcase
          put(inner);
        end
        put(dfp_pkg::QUOTE_BYTE);
        if ($urandom_range(3) == 0) begin
          put(dfp_pkg::QUOTE_BYTE);
          put_letters($urandom_range(1, 3));
          put(dfp_pkg::QUOTE_BYTE);
        end
        if ($urandom_range(4) == 0)
          put_letters(1);
      end
      7: begin
        put_digits($urandom_range(1, 3));
        put_letters(1);
        put_digits($urandom_range(0, 3));
      end
      8: begin
        put_digits($urandom_range(1, 2));
        put(profile.point_byte);
        put_digits($urandom_range(0, 2));
        put(profile.point_byte);
        put_digits($urandom_range(0, 2));
      end
      9: ;
      10: repeat ($urandom_range(1, 5)) put(8'($urandom_range(255)));
      default: begin
        put_digits($urandom_range(1, 3));
        put(profile.point_byte);
        put_digits($urandom_range(1, 2));
        put_letters(1);
      end
    endcase
  endtask

  // One line of text. A fresh stream under header skipping starts with a
  // header line; now and then the stream ends mid-field or between lines.
  task automatic put_row();
    int fields;
    if (profile.mode == dfp_pkg::MODE_IDLE && profile.skip_hdr) begin
      put_letters($urandom_range(2, 6));
      put(profile.sep_byte);
      put_letters($urandom_range(1, 4));
      if ($urandom_range(9) == 0) begin
        end_stream();
        return;
      end
      put(dfp_pkg::NEWLINE_BYTE);
    end
    fields = $urandom_range(1, 6);
    for (int f = 0; f < fields; f++) begin
      put_field();
      if ($urandom_range(49) == 0) begin
        end_stream();
        return;
      end
      if (f == fields - 1)
        put(dfp_pkg::NEWLINE_BYTE);
      else
        put(profile.sep_byte);
    end
    if ($urandom_range(29) == 0)
      end_stream();
  endtask

  // A run of random lines under one register setting. Phases do not end the
  // stream, so a lower column count takes effect in the middle of one.
  task automatic run_phase(input logic [7:0] sep, input logic [7:0] dec, input logic skip,
                           input logic [7:0] cols, input int n, input bit squeeze);
    int target;
    drain();
    write_settings(sep, dec, skip, cols);
    if (squeeze)
      hold_asked++;
    target = beats_sent + n;
    while (beats_sent < target)
      put_row();
  endtask

  // Result side: checks every accepted result beat against the oldest pending
  // field, and picks out_ready for the next cycle.
  initial begin : result_sink
    field_rec_t got;
    int         hold_left;
    int         hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.column  = out_column_index;
        got.kind    = dfp_pkg::dfp_kind_t'(out_field_kind);
        got.length  = out_field_length;
        got.kinds   = out_kinds_seen;
        got.longest = out_longest_length;
        got.last    = out_final_field;
        profile.match_field(got);
      end
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_LONG;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin : stimulus
    profile = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'd0;
    in_end_of_data <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= dfp_pkg::CFG_SEPARATOR;
    cfg_wdata      <= 8'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines with the default separator and decimal point, three
    // columns and the header skipped.
    write_settings(dfp_pkg::SEPARATOR_RST, dfp_pkg::DECIMAL_RST, 1'b1, 8'd3);
    send_beat(8'h00, 1'b1);                 // end of data before any byte
    put("h");
    put(dfp_pkg::NEWLINE_BYTE);             // header line swallowed
    put("1"); put("2"); put(",");           // integer
    put("3"); put("."); put("5"); put(","); // decimal
    put(dfp_pkg::QUOTE_BYTE); put(",");     // separator masked by the quote
    put(dfp_pkg::QUOTE_BYTE); put(",");
    put("1"); put("."); put(".");           // second point turns it into text
    put(dfp_pkg::NEWLINE_BYTE);
    put(8'hFF); put(8'h00); put(",");       // extreme byte values as text
    put(",");                               // empty field after a separator
    send_beat(8'hA5, 1'b1);                 // closes that empty field
    put("x");
    send_beat(8'h5A, 1'b1);                 // end of data inside the header

    // One longer text field followed by short ones; no idling here.
    drain();
    write_settings(dfp_pkg::SEPARATOR_RST, dfp_pkg::DECIMAL_RST, 1'b0, 8'd3);
    calm = 1'b1;
    repeat (60) put("a");
    put(",");
    put("7");
    put(dfp_pkg::NEWLINE_BYTE);
    calm = 1'b0;

    run_phase(dfp_pkg::SEPARATOR_RST, dfp_pkg::DECIMAL_RST, 1'b0, 8'd4, 300, 1'b0);
    // A long stretch with no idling on either side, all 64 columns in use.
    calm = 1'b1;
    run_phase(8'd9, 8'd44, 1'b1, 8'd64, 250, 1'b0);
    calm = 1'b0;
    // The result side holds off here while beats keep coming.
    run_phase(8'd0, 8'd255, 1'b0, 8'd1, 200, 1'b1);
    run_phase(8'd255, 8'd0, 1'b1, 8'd2, 200, 1'b0);
    run_phase(8'd59, dfp_pkg::DECIMAL_RST, 1'b0, 8'd0, 150, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 1'($urandom), 8'hFF, 200, 1'b0);
    run_phase(dfp_pkg::SEPARATOR_RST, dfp_pkg::DECIMAL_RST, 1'b1,
              8'($urandom_range(1, 64)), 375, 1'b0);
    run_phase(dfp_pkg::QUOTE_BYTE, dfp_pkg::DECIMAL_RST, 1'b0, 8'd5, 150, 1'b0);
    run_phase(dfp_pkg::NEWLINE_BYTE, dfp_pkg::DECIMAL_RST, 1'b0, 8'd3, 100, 1'b0);

    drain();
    if (profile.failures == 0 && profile.pending_fields.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
